// ===== rtl/core/vfd_pkg.sv =====
// Shared types and constants of the voice frame deframer.
// Used by the front classifier, the op queue, the back end and the top level.
// No dependencies.
package vfd_pkg;

  localparam int POS_W  = 6;
  localparam int BYTE_W = 8;
  localparam int CH_W   = 4;
  localparam int SLOT_W = 7;
  localparam int KIND_W = 2;
  localparam int IDX_W  = 2;

  // Configuration register indexes.
  localparam logic [IDX_W-1:0] REG_HEADER_FIRST     = 2'd0;
  localparam logic [IDX_W-1:0] REG_HEADER_SECOND    = 2'd1;
  localparam logic [IDX_W-1:0] REG_FRAMES_PER_BLOCK = 2'd2;

  localparam logic [BYTE_W-1:0] HEADER_FIRST_RESET     = 8'h9A;
  localparam logic [BYTE_W-1:0] HEADER_SECOND_RESET    = 8'h7E;
  localparam logic [BYTE_W-1:0] FRAMES_PER_BLOCK_RESET = 8'd16;
  localparam logic [BYTE_W-1:0] BLOCK_MAX              = 8'd128;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOST   = 2'd2;

  // Operations handed from the front to the back.
  typedef enum logic [2:0] {
    OP_LOCK = 3'd0,
    OP_HEAD = 3'd1,
    OP_ID   = 3'd2,
    OP_UP   = 3'd3,
    OP_DOWN = 3'd4,
    OP_PAD  = 3'd5,
    OP_SUM  = 3'd6,
    OP_LOST = 3'd7
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CH_W-1:0]   ch;
    logic [BYTE_W-1:0] data;
  } op_entry_t;

  typedef struct packed {
    logic [BYTE_W-1:0] header_first;
    logic [BYTE_W-1:0] header_second;
    logic [BYTE_W-1:0] frames_per_block;
  } cfg_t;

endpackage

// ===== rtl/core/voice_frame_deframer.sv =====
// Voice frame deframer: hunts for a two-byte header, then splits each frame of
// 3*CHANNELS+4 bytes into per-channel sample words, a frame end status word
// (checksum verdict, block completion) and, on a broken header, a sync lost word.
// It takes one byte per clock while full is low; a result passes through the op
// queue and the result register before it reaches the ports. The rate is set by the
// classifier in the front and the op handling in the back, which are joined by a
// QUEUE_DEPTH-entry op queue, so that output stalls reach full only once it fills.
// Configuration must be written while no words are in flight. Depends on vfd_pkg.
module voice_frame_deframer #(
  parameter int CHANNELS    = 12,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [vfd_pkg::IDX_W-1:0]   cfg_index,
  input  logic [vfd_pkg::BYTE_W-1:0]  cfg_data,
  input  logic                        push,
  output logic                        full,
  input  logic [vfd_pkg::BYTE_W-1:0]  rx_byte,
  output logic                        empty,
  input  logic                        pop,
  output logic [vfd_pkg::KIND_W-1:0]  kind,
  output logic [vfd_pkg::CH_W-1:0]    channel,
  output logic [vfd_pkg::BYTE_W-1:0]  channel_id,
  output logic [vfd_pkg::BYTE_W-1:0]  up_sample,
  output logic [vfd_pkg::BYTE_W-1:0]  down_sample,
  output logic [vfd_pkg::SLOT_W-1:0]  frame_slot,
  output logic                        checksum_ok,
  output logic                        block_done
);

  vfd_pkg::cfg_t      cfg;
  logic               accept, fr_valid, q_valid, q_take, res_valid;
  vfd_pkg::op_entry_t fr_entry, q_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.header_first     <= vfd_pkg::HEADER_FIRST_RESET;
      cfg.header_second    <= vfd_pkg::HEADER_SECOND_RESET;
      cfg.frames_per_block <= vfd_pkg::FRAMES_PER_BLOCK_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        vfd_pkg::REG_HEADER_FIRST:     cfg.header_first     <= cfg_data;
        vfd_pkg::REG_HEADER_SECOND:    cfg.header_second    <= cfg_data;
        vfd_pkg::REG_FRAMES_PER_BLOCK: cfg.frames_per_block <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept = push && !full;
  assign empty  = !res_valid;

  vfd_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .accept   (accept),
    .rx_byte  (rx_byte),
    .op_valid (fr_valid),
    .op_entry (fr_entry)
  );

  vfd_op_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (fr_valid),
    .wr_data  (fr_entry),
    .full     (full),
    .rd_valid (q_valid),
    .rd_en    (q_take),
    .rd_data  (q_entry)
  );

  vfd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .op_valid    (q_valid),
    .op_entry    (q_entry),
    .op_take     (q_take),
    .pop         (pop),
    .res_valid   (res_valid),
    .kind        (kind),
    .channel     (channel),
    .channel_id  (channel_id),
    .up_sample   (up_sample),
    .down_sample (down_sample),
    .frame_slot  (frame_slot),
    .checksum_ok (checksum_ok),
    .block_done  (block_done)
  );

endmodule

// ===== rtl/core/vfd_front.sv =====
// Front end of the deframer: accepts bytes, tracks sync and frame position,
// and turns the locking byte and each byte in sync into an operation word for the back end.
// Depends on vfd_pkg.
module vfd_front #(
  parameter int CHANNELS = 12
) (
  input  logic                      clk,
  input  logic                      rst,
  input  vfd_pkg::cfg_t             cfg,
  input  logic                      accept,
  input  logic [vfd_pkg::BYTE_W-1:0] rx_byte,
  output logic                      op_valid,
  output vfd_pkg::op_entry_t        op_entry
);

  localparam int PAD_POS = 3 * CHANNELS + 2;

  logic                       in_sync, in_sync_next;
  logic                       saw_first, saw_first_next;
  logic [vfd_pkg::POS_W-1:0]  pos, pos_next;
  logic [1:0]                 phase, phase_next;
  logic [vfd_pkg::CH_W-1:0]   ch, ch_next;
  logic                       is_first, is_second;

  assign is_first  = (rx_byte == cfg.header_first);
  assign is_second = (rx_byte == cfg.header_second);

  always_comb begin
    in_sync_next   = in_sync;
    saw_first_next = saw_first;
    pos_next       = pos;
    phase_next     = phase;
    ch_next        = ch;
    op_valid       = 1'b0;
    op_entry.op    = vfd_pkg::OP_HEAD;
    op_entry.ch    = ch;
    op_entry.data  = rx_byte;
    if (accept) begin
      if (!in_sync) begin
        if (saw_first && is_second) begin
          op_valid       = 1'b1;
          op_entry.op    = vfd_pkg::OP_LOCK;
          in_sync_next   = 1'b1;
          saw_first_next = 1'b0;
          pos_next       = vfd_pkg::POS_W'(2);
          phase_next     = 2'd0;
          ch_next        = '0;
        end else begin
          saw_first_next = is_first;
        end
      end else begin
        op_valid = 1'b1;
        if ((pos == '0 && !is_first) || (pos == vfd_pkg::POS_W'(1) && !is_second)) begin
          op_entry.op    = vfd_pkg::OP_LOST;
          in_sync_next   = 1'b0;
          saw_first_next = is_first;
          pos_next       = '0;
        end else if (pos < vfd_pkg::POS_W'(2)) begin
          op_entry.op = vfd_pkg::OP_HEAD;
          pos_next    = pos + vfd_pkg::POS_W'(1);
          phase_next  = 2'd0;
          ch_next     = '0;
        end else if (pos < vfd_pkg::POS_W'(PAD_POS)) begin
          pos_next = pos + vfd_pkg::POS_W'(1);
          case (phase)
            2'd0: begin
              op_entry.op = vfd_pkg::OP_ID;
              phase_next  = 2'd1;
            end
            2'd1: begin
              op_entry.op = vfd_pkg::OP_UP;
              phase_next  = 2'd2;
            end
            default: begin
              op_entry.op = vfd_pkg::OP_DOWN;
              phase_next  = 2'd0;
              ch_next     = ch + vfd_pkg::CH_W'(1);
            end
          endcase
        end else if (pos == vfd_pkg::POS_W'(PAD_POS)) begin
          op_entry.op = vfd_pkg::OP_PAD;
          pos_next    = pos + vfd_pkg::POS_W'(1);
        end else begin
          // Anything at or beyond the checksum position closes the frame.
          op_entry.op = vfd_pkg::OP_SUM;
          pos_next    = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_sync   <= 1'b0;
      saw_first <= 1'b0;
      pos       <= '0;
      phase     <= 2'd0;
      ch        <= '0;
    end else begin
      in_sync   <= in_sync_next;
      saw_first <= saw_first_next;
      pos       <= pos_next;
      phase     <= phase_next;
      ch        <= ch_next;
    end
  end

  // While hunting the position is parked at zero and a lock clears the half match.
  a_hunt_pos: assert property (@(posedge clk) disable iff (rst) !in_sync |-> pos == '0)
    else $error("position moved while hunting");
  a_sync_clear: assert property (@(posedge clk) disable iff (rst) in_sync |-> !saw_first)
    else $error("half header match left set while in sync");

endmodule

// ===== rtl/core/vfd_op_queue.sv =====
// Short queue of operation words between the front and the back end.
// Depends on vfd_pkg.
module vfd_op_queue #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  vfd_pkg::op_entry_t wr_data,
  output logic               full,
  output logic               rd_valid,
  input  logic               rd_en,
  output vfd_pkg::op_entry_t rd_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  vfd_pkg::op_entry_t store [DEPTH];
  logic [AW-1:0]      wr_ptr, rd_ptr;
  logic [CW-1:0]      cnt;
  logic               do_wr, do_rd;

  assign full     = (cnt == CW'(DEPTH));
  assign rd_valid = (cnt != '0);
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;
  assign rd_data  = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt <= cnt + CW'(1);
      end else if (do_rd && !do_wr) begin
        cnt <= cnt - CW'(1);
      end
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt <= CW'(DEPTH))
    else $error("op queue fill count beyond depth");

endmodule

// ===== rtl/core/vfd_back.sv =====
// Back end of the deframer: carries out operation words, keeps the checksum,
// held triplet bytes and block count, and holds the result register.
// Depends on vfd_pkg.
module vfd_back (
  input  logic                        clk,
  input  logic                        rst,
  input  vfd_pkg::cfg_t               cfg,
  input  logic                        op_valid,
  input  vfd_pkg::op_entry_t          op_entry,
  output logic                        op_take,
  input  logic                        pop,
  output logic                        res_valid,
  output logic [vfd_pkg::KIND_W-1:0]  kind,
  output logic [vfd_pkg::CH_W-1:0]    channel,
  output logic [vfd_pkg::BYTE_W-1:0]  channel_id,
  output logic [vfd_pkg::BYTE_W-1:0]  up_sample,
  output logic [vfd_pkg::BYTE_W-1:0]  down_sample,
  output logic [vfd_pkg::SLOT_W-1:0]  frame_slot,
  output logic                        checksum_ok,
  output logic                        block_done
);

  logic [vfd_pkg::BYTE_W-1:0] sum, held_id, held_up;
  logic [vfd_pkg::SLOT_W-1:0] count;
  logic                       has_result, out_free, load;
  logic [vfd_pkg::BYTE_W-1:0] limit, next_count;
  logic                       done;

  assign has_result = (op_entry.op == vfd_pkg::OP_DOWN) || (op_entry.op == vfd_pkg::OP_SUM)
                   || (op_entry.op == vfd_pkg::OP_LOST);
  assign out_free   = !res_valid || pop;
  assign op_take    = op_valid && (out_free || !has_result);
  assign load       = op_take && has_result;

  // Block length is clamped to one through one hundred and twenty-eight frames.
  always_comb begin
    if (cfg.frames_per_block == '0) begin
      limit = vfd_pkg::BYTE_W'(1);
    end else if (cfg.frames_per_block > vfd_pkg::BLOCK_MAX) begin
      limit = vfd_pkg::BLOCK_MAX;
    end else begin
      limit = cfg.frames_per_block;
    end
    next_count = {1'b0, count} + vfd_pkg::BYTE_W'(1);
    done       = (next_count >= limit);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum     <= '0;
      held_id <= '0;
      held_up <= '0;
      count   <= '0;
    end else if (op_take) begin
      case (op_entry.op)
        vfd_pkg::OP_LOCK: sum <= cfg.header_first + op_entry.data;
        vfd_pkg::OP_ID: begin
          sum     <= sum + op_entry.data;
          held_id <= op_entry.data;
        end
        vfd_pkg::OP_UP: begin
          sum     <= sum + op_entry.data;
          held_up <= op_entry.data;
        end
        vfd_pkg::OP_SUM: begin
          sum   <= '0;
          count <= done ? '0 : next_count[vfd_pkg::SLOT_W-1:0];
        end
        vfd_pkg::OP_LOST: begin
          sum   <= '0;
          count <= '0;
        end
        default: sum <= sum + op_entry.data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (pop) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      channel     <= '0;
      channel_id  <= '0;
      up_sample   <= '0;
      down_sample <= '0;
      frame_slot  <= count;
      checksum_ok <= 1'b0;
      block_done  <= 1'b0;
      case (op_entry.op)
        vfd_pkg::OP_DOWN: begin
          kind        <= vfd_pkg::KIND_SAMPLE;
          channel     <= op_entry.ch;
          channel_id  <= held_id;
          up_sample   <= held_up;
          down_sample <= op_entry.data;
        end
        vfd_pkg::OP_SUM: begin
          kind        <= vfd_pkg::KIND_STATUS;
          checksum_ok <= (sum == op_entry.data);
          block_done  <= done;
        end
        default: begin
          kind       <= vfd_pkg::KIND_LOST;
          frame_slot <= '0;
        end
      endcase
    end
  end

  // A waiting word must survive a cycle in which it is not taken.
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
      res_valid && !pop |=> res_valid && $stable(kind) && $stable(frame_slot))
    else $error("result word changed before it was taken");
  a_lost_fields: assert property (@(posedge clk) disable iff (rst)
      res_valid && kind == vfd_pkg::KIND_LOST |-> frame_slot == '0 && channel == '0)
    else $error("sync lost word carries frame fields");

endmodule
